// File: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clock, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge of clock outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: hw/rtl/ssc_pkg.sv
// Package with the constants, payload types and control structs of the subset sum counter.
package ssc_pkg;

   localparam int MaxTarget    = 1023;
   localparam int CountWidth   = 32;
   localparam int TableDepth   = MaxTarget + 1;
   localparam int AddrWidth    = $clog2(TableDepth);
   localparam int ElemWidth    = 16;
   localparam int TargetWidth  = 10;
   localparam int RspCntWidth  = 32;

   localparam logic [CountWidth-1:0] CountLimit = {CountWidth{1'b1}};

   typedef struct packed {
      logic [ElemWidth-1:0] elem_value;
      logic                 last_elem;
   } ssc_req_type;

   typedef struct packed {
      logic [RspCntWidth-1:0] subset_count;
      logic                   count_saturated;
   } ssc_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic clear_step;
      logic finish;
   } ssc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic no_work;
      logic at_low;
      logic at_zero;
   } ssc_status_type;

endpackage

// File: hw/rtl/ssc_ram.sv
// Generic RAM with one write port and two registered read ports.
module ssc_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr_a,
   output logic [Width-1:0]         rd_data_a,
   input  logic [$clog2(Depth)-1:0] rd_addr_b,
   output logic [Width-1:0]         rd_data_b
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_a_ff;
   logic [Width-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: hw/rtl/ssc_datapath.sv
// Datapath of the subset sum counter: count table, address counter, saturating adder, result.
module ssc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  ssc_pkg::ssc_cmd_type   cmd,
   output ssc_pkg::ssc_status_type status,
   input  ssc_pkg::ssc_req_type   req_data,
   input  logic                   csr_wr_en,
   input  logic [ssc_pkg::TargetWidth-1:0] csr_wr_data,
   output logic                   rsp_strobe,
   output ssc_pkg::ssc_rsp_type   rsp_data
);
   import ssc_pkg::*;

   logic [AddrWidth-1:0]   addr_ff, addr_in;
   logic [ElemWidth-1:0]   elem_ff, elem_in;
   logic                   last_ff, last_in;
   logic [TargetWidth-1:0] target_ff, target_in;

   logic                   st1_vld_ff, st1_vld_in;
   logic [AddrWidth-1:0]   st1_addr_ff, st1_addr_in;
   logic                   st1_add_ff, st1_add_in;

   logic [CountWidth-1:0]  cap_ff, cap_in;
   logic                   sat_ff, sat_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   ssc_rsp_type            rsp_data_ff, rsp_data_in;

   logic [AddrWidth-1:0]   low_addr;
   logic                   add_now;
   logic [AddrWidth-1:0]   rd_addr_b;
   logic [CountWidth-1:0]  rd_data_a;
   logic [CountWidth-1:0]  rd_data_b;
   logic [CountWidth:0]    sum;
   logic                   sat_now;
   logic                   sat_hit;
   logic [CountWidth-1:0]  new_count;
   logic                   tgt_hit;
   logic                   wr_en;
   logic [AddrWidth-1:0]   wr_addr;
   logic [CountWidth-1:0]  wr_data;

   function automatic logic [CountWidth-1:0] reset_value(input logic [AddrWidth-1:0] addr);
      reset_value = (addr == '0) ? CountWidth'(1) : '0;
   endfunction

   // The last element sweeps the whole table so that it is cleared on the way.
   assign low_addr = last_ff ? '0 : elem_ff[AddrWidth-1:0];
   assign add_now  = ElemWidth'(addr_ff) >= elem_ff;
   assign rd_addr_b = addr_ff - elem_ff[AddrWidth-1:0];

   assign status.no_work = (req_data.elem_value > ElemWidth'(MaxTarget)) && !req_data.last_elem;
   assign status.at_low  = (addr_ff == low_addr);
   assign status.at_zero = (addr_ff == '0);

   always_comb begin
      addr_in = addr_ff;
      if (cmd.load) begin
         addr_in = AddrWidth'(MaxTarget);
      end else if (cmd.step || cmd.clear_step) begin
         addr_in = addr_ff - AddrWidth'(1);
      end
   end

   assign elem_in   = cmd.load ? req_data.elem_value : elem_ff;
   assign last_in   = cmd.load ? req_data.last_elem : last_ff;
   assign target_in = csr_wr_en ? csr_wr_data : target_ff;

   assign st1_vld_in  = cmd.step;
   assign st1_addr_in = addr_ff;
   assign st1_add_in  = add_now;

   // Entries below the element value take no addend and never saturate.
   assign sum       = {1'b0, rd_data_a} + (st1_add_ff ? {1'b0, rd_data_b} : '0);
   assign sat_now   = st1_add_ff && (sum >= {1'b0, CountLimit});
   assign new_count = sat_now ? CountLimit : sum[CountWidth-1:0];
   assign sat_hit   = st1_vld_ff && sat_now;
   assign tgt_hit   = st1_vld_ff && (st1_addr_ff == target_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = st1_addr_ff;
      wr_data = new_count;
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = addr_ff;
         wr_data = reset_value(addr_ff);
      end else if (st1_vld_ff) begin
         wr_en   = 1'b1;
         wr_data = last_ff ? reset_value(st1_addr_ff) : new_count;
      end
   end

   assign cap_in = tgt_hit ? new_count : cap_ff;
   assign sat_in = (cmd.finish && last_ff) ? 1'b0 : (sat_ff || sat_hit);

   assign rsp_strobe_in = cmd.finish && last_ff;
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_strobe_in) begin
         rsp_data_in.subset_count    = tgt_hit ? new_count : cap_ff;
         rsp_data_in.count_saturated = sat_ff || sat_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= AddrWidth'(MaxTarget);
         target_ff     <= '0;
         st1_vld_ff    <= 1'b0;
         sat_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         addr_ff       <= addr_in;
         target_ff     <= target_in;
         st1_vld_ff    <= st1_vld_in;
         sat_ff        <= sat_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff     <= elem_in;
      last_ff     <= last_in;
      st1_addr_ff <= st1_addr_in;
      st1_add_ff  <= st1_add_in;
      cap_ff      <= cap_in;
      rsp_data_ff <= rsp_data_in;
   end

   ssc_ram #(
      .Width (CountWidth),
      .Depth (TableDepth)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (addr_ff),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// File: hw/rtl/ssc_ctrl.sv
// Controller state machine of the subset sum counter: clearing pass, sweep and drain.
module ssc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  ssc_pkg::ssc_status_type status,
   output ssc_pkg::ssc_cmd_type    cmd
);
   import ssc_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SWEEP = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.at_zero) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // An element above every sum that is not the last one changes nothing.
            if (start && !status.no_work) begin
               cmd.load = 1'b1;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cmd.step = 1'b1;
            if (status.at_low) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: hw/rtl/subset_sum_count_core.sv
// Top level of the subset sum counter: controller, datapath and port assertions.
//
// Elements of a set arrive one per item on req_data; an item is taken at a
// rising edge with start high and busy low. The item marked last_elem yields
// one result on rsp_data, shown for exactly one cycle with rsp_strobe high;
// the receiver cannot stall it. Other items yield no result.
// The user writes the target sum via csr_wr_en and csr_wr_data only while
// idle; the block does not enforce this. The count table is a 1024-entry RAM
// swept one entry per cycle, from the top sum down, with a read-add-write
// pipeline of one stage. An element of value v that is not the last keeps
// busy high through its sweep down to entry v and the drain state; one of
// value above 1023 that is not the last is taken with no busy time at all.
// The last element sweeps all 1024 entries, clearing the table as it goes, and
// shows its result in the first idle cycle. After reset a clearing pass
// loads the table, with busy high; configuration writes are taken during it.
`include "assert_macros.svh"

module subset_sum_count_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  ssc_pkg::ssc_req_type           req_data,
   input  logic                           csr_wr_en,
   input  logic [ssc_pkg::TargetWidth-1:0] csr_wr_data,
   output logic                           rsp_strobe,
   output ssc_pkg::ssc_rsp_type           rsp_data
);
   import ssc_pkg::*;

   ssc_cmd_type    cmd;
   ssc_status_type status;

   ssc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   ssc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

   // Results come after a full sweep, so two never follow each other.
   `ASSERT_CLK(a_no_back_to_back_rsp, rsp_strobe |=> !rsp_strobe, "two results in a row")
   // A result is shown only once the sweep has ended and the block is idle.
   `ASSERT_NEVER(a_rsp_while_busy, rsp_strobe && busy, "result while busy")
   // An item just taken cannot produce a result in the next cycle.
   `ASSERT_CLK(a_no_rsp_after_accept, (start && !busy) |=> !rsp_strobe, "result too early")

endmodule

// File: sim/tb.sv
// Self-checking testbench for the subset sum counter core.
`timescale 1ns / 1ps

module tb;
   import ssc_pkg::*;

   localparam int QuietLimit   = 20000;
   localparam int SettleCycles = 1030;
   localparam int MaxPrinted   = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   ssc_req_type req_data = '0;
   logic        csr_wr_en = 1'b0;
   logic [TargetWidth-1:0] csr_wr_data = '0;
   logic        rsp_strobe;
   ssc_rsp_type rsp_data;

   subset_sum_count_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the count table and the target register.
   logic [CountWidth-1:0]  sum_ways [TableDepth];
   logic                   sat_any;
   logic [TargetWidth-1:0] target_model;

   ssc_req_type elem_queue[$];
   ssc_rsp_type pending_answers[$];

   int unsigned mismatch_count = 0;
   int unsigned elems_queued   = 0;
   int unsigned elems_taken    = 0;
   int unsigned results_seen   = 0;
   int unsigned sat_results    = 0;
   int unsigned target_writes  = 0;
   int unsigned quiet_cycles   = 0;
   int          send_wait      = 0;
   bit          rush_mode      = 1'b0;
   logic        drive_next;
   ssc_rsp_type want;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MaxPrinted)
         $display("%0t ns MISMATCH: %s", $realtime, what);
   endtask

   task automatic clear_table();
      for (int s = 0; s < TableDepth; s++)
         sum_ways[s] = '0;
      sum_ways[0] = 1;
      sat_any = 1'b0;
   endtask

   // Descending sweep so each entry reads the count from before this element.
   task automatic apply_element(input ssc_req_type item);
      int v;
      logic [CountWidth:0] total;
      ssc_rsp_type answer;
      v = int'(item.elem_value);
      for (int s = MaxTarget; s >= v; s--) begin
         total = {1'b0, sum_ways[s]} + {1'b0, sum_ways[s - v]};
         if (total >= {1'b0, CountLimit}) begin
            sum_ways[s] = CountLimit;
            sat_any = 1'b1;
         end else begin
            sum_ways[s] = total[CountWidth-1:0];
         end
      end
      if (item.last_elem) begin
         answer.subset_count = sum_ways[target_model];
         answer.count_saturated = sat_any;
         pending_answers.push_back(answer);
         clear_table();
      end
   endtask

   // Driver: sends queued elements, with a random gap after each one taken, or none in rush mode.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         send_wait = 0;
      end else begin
         drive_next = start;
         if (start && !busy) begin
            apply_element(req_data);
            elems_taken++;
            drive_next = 1'b0;
            send_wait = rush_mode ? 0 : $urandom_range(0, 11);
         end
         if (!drive_next) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (elem_queue.size() > 0) begin
               req_data <= elem_queue.pop_front();
               drive_next = 1'b1;
            end
         end
         start <= drive_next;
      end
   end

   // Monitor: every strobed result must match the oldest predicted answer.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (rsp_data.count_saturated)
            sat_results++;
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending, count %0d",
                                      rsp_data.subset_count));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.subset_count !== want.subset_count)
               report_mismatch($sformatf("subset_count %0d, predicted %0d",
                                         rsp_data.subset_count, want.subset_count));
            if (rsp_data.count_saturated !== want.count_saturated)
               report_mismatch($sformatf("count_saturated %b, predicted %b",
                                         rsp_data.count_saturated, want.count_saturated));
         end
      end
   end

   // Watchdog on cycles in which nothing moves on any port.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("Timeout: no activity for %0d cycles", QuietLimit);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_elem(input int unsigned value, input bit last);
      ssc_req_type item;
      item.elem_value = value[ElemWidth-1:0];
      item.last_elem = last;
      elem_queue.push_back(item);
      elems_queued++;
   endtask

   // Waits until every element is taken and every answer has arrived, then
   // lets a full sweep pass in case a non-last element is still in work.
   task automatic drain_block();
      do
         @(negedge clock);
      while (elem_queue.size() != 0 || start || pending_answers.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_target(input int unsigned value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[TargetWidth-1:0];
      target_model = value[TargetWidth-1:0];
      target_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int unsigned pick_value(input int unsigned tgt);
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 14)
         return $urandom_range(0, tgt);
      else if (r < 17)
         return $urandom_range(0, 3);
      else
         return $urandom_range(0, 65535);
   endfunction

   task automatic queue_set(input int unsigned tgt);
      int unsigned kind;
      int unsigned len;
      int unsigned zeros;
      int unsigned extras;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         len = $urandom_range(1, 8);
         for (int i = 1; i < len; i++)
            add_elem(pick_value(tgt), 1'b0);
         add_elem(($urandom_range(0, 4) == 0) ? tgt : pick_value(tgt), 1'b1);
      end else if (kind < 8) begin
         // Enough zero elements to push the counts close to or past saturation.
         zeros = $urandom_range(30, 34);
         extras = $urandom_range(1, 4);
         while (zeros + extras > 1) begin
            if (extras > 0 && ($urandom_range(0, 7) == 0 || zeros == 0)) begin
               add_elem($urandom_range(0, tgt), 1'b0);
               extras--;
            end else begin
               add_elem(0, 1'b0);
               zeros--;
            end
         end
         add_elem((extras > 0) ? $urandom_range(0, tgt) : 0, 1'b1);
      end else begin
         len = $urandom_range(1, 3);
         for (int i = 1; i < len; i++)
            add_elem($urandom_range(0, 65535), 1'b0);
         add_elem($urandom_range(0, 65535), 1'b1);
      end
   endtask

   initial begin
      int unsigned tgt;
      int unsigned phase_start;
      clear_table();
      target_model = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_target(0);

      // Zero-valued first element, oversized values, element at the table top.
      add_elem(0, 1'b1);
      add_elem(65535, 1'b1);
      add_elem(1024, 1'b0);
      add_elem(1023, 1'b1);
      add_elem(5, 1'b0);
      add_elem(0, 1'b1);
      drain_block();
      write_target(MaxTarget);
      add_elem(1023, 1'b1);
      add_elem(1000, 1'b0);
      add_elem(23, 1'b1);
      add_elem(512, 1'b0);
      add_elem(511, 1'b0);
      add_elem(0, 1'b1);
      // The target changes between elements of one set.
      add_elem(2, 1'b0);
      add_elem(3, 1'b0);
      drain_block();
      write_target(5);
      add_elem(0, 1'b1);
      add_elem(16'hAAAA, 1'b0);
      add_elem(16'h5555, 1'b1);
      add_elem(1, 1'b0);
      add_elem(4, 1'b1);
      drain_block();

      for (int phase = 0; elems_queued < 580; phase++) begin
         case (phase % 4)
            0: tgt = (phase % 8 == 0) ? MaxTarget : 0;
            1: tgt = $urandom_range(1, 40);
            default: tgt = $urandom_range(0, MaxTarget);
         endcase
         write_target(tgt);
         rush_mode = ($urandom_range(0, 3) == 0);
         phase_start = elems_queued;
         while (elems_queued - phase_start < 90 && elems_queued < 580)
            queue_set(tgt);
         drain_block();
      end

      $display("Ran %0d elements in %0d sets over %0d target settings.",
               elems_taken, results_seen, target_writes);
      $display("%0d results carried the saturation flag; %0d mismatches.",
               sat_results, mismatch_count);
      if (mismatch_count == 0 && pending_answers.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
